### rtl/energy_beat_detector_bpm_top_defines.svh
// Assertion macros for the energy beat detector.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ENERGY_BEAT_DETECTOR_BPM_TOP_DEFINES_SVH
`define ENERGY_BEAT_DETECTOR_BPM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define EBD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define EBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EBD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define EBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/ebd_pkg.sv
// Shared types and constants for the energy beat detector.
// No dependencies.
package ebd_pkg;

  localparam int unsigned DEF_HISTORY_DEPTH  = 64;
  localparam int unsigned DEF_INTERVAL_DEPTH = 16;

  localparam int unsigned ENERGY_W    = 16;
  localparam int unsigned STEP_W      = 20;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned GAP_W       = 24;
  localparam int unsigned SENS_W      = 9;
  localparam int unsigned THR_W       = SENS_W + 2;
  localparam int unsigned TEMPO_W     = 13;
  localparam int unsigned TEMPO_NUM_W = 30;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [GAP_W-1:0]       GAP_MAX     = '1;
  localparam logic [TEMPO_NUM_W-1:0] TEMPO_NUM   = 30'd960000000;
  localparam logic [TEMPO_W-1:0]     TEMPO_MIN   = 13'd640;
  localparam logic [TEMPO_W-1:0]     TEMPO_MAX   = 13'd4800;
  localparam logic [TEMPO_W-1:0]     TEMPO_RESET = 13'd1920;

  localparam logic [SENS_W-1:0]   SENS_RESET  = 9'd128;
  localparam logic [ENERGY_W-1:0] FLOOR_RESET = 16'd655;
  localparam logic [GAP_W-1:0]    GAP_RESET   = 24'd100000;

  localparam logic [CFG_INDEX_W-1:0] CFG_SENSITIVITY  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENERGY_FLOOR = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GAP      = 2'd2;

  typedef struct packed {
    logic [ENERGY_W-1:0] frame_energy;
    logic [STEP_W-1:0]   time_step_us;
  } in_item_t;

  typedef struct packed {
    logic               beat;
    logic [TEMPO_W-1:0] tempo_x16;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERD,
    ST_MUL_E,
    ST_MUL_S,
    ST_CMP,
    ST_IRD,
    ST_NUM,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### rtl/ebd_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
// Payload types come from ebd_pkg.
interface ebd_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/ebd_div.sv
// Restoring divider, one quotient bit per cycle.
// Stand-alone; used by the top level for the tempo quotient.
module ebd_div #(
  parameter int unsigned NUM_W = 35,
  parameter int unsigned DEN_W = 29
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};
  assign quot  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

### rtl/energy_beat_detector_bpm_top.sv
// Energy onset beat detector with tempo estimate; top level.
// Uses ebd_pkg, ebd_stream_if, ebd_div and the assertion macro header.
//
//  port      dir  item                          handshake
//  frames    in   frame_energy, time_step_us    valid/ready
//  results   out  beat, tempo_x16               valid/ready
//  cfg_*     in   register index, write data    write enable
//
// One item at a time: after accept a frame passes ST_ERD, ST_MUL_E, ST_MUL_S
// and ST_CMP, then ST_DONE; an interval being recorded adds ST_IRD and ST_NUM,
// and a nonzero interval sum recomputes the tempo in the serial divider
// (NUM_W = 30 + clog2(INTERVAL_DEPTH+1), so 35 at the default).
// Energy and interval histories live in single-port-style RAMs read in the
// cycle before the update. Sync reset; no clearing pass is needed.
// A new frame is accepted while the previous result waits in the output
// register; a stalled result holds only the final stage.
`include "energy_beat_detector_bpm_top_defines.svh"

module energy_beat_detector_bpm_top import ebd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH  = DEF_HISTORY_DEPTH,
  parameter int unsigned INTERVAL_DEPTH = DEF_INTERVAL_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ebd_stream_if.sink             frames,
  ebd_stream_if.source           results
);

  localparam int unsigned HAW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned ECW   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned ESW   = ENERGY_W + ECW;
  localparam int unsigned IAW   = (INTERVAL_DEPTH > 1) ? $clog2(INTERVAL_DEPTH) : 1;
  localparam int unsigned ICW   = $clog2(INTERVAL_DEPTH + 1);
  localparam int unsigned ISW   = GAP_W + ICW;
  localparam int unsigned NUM_W = TEMPO_NUM_W + ICW;
  localparam int unsigned PEW   = ENERGY_W + ECW;
  localparam int unsigned CMP_W = ESW + THR_W;

  // configuration
  logic [SENS_W-1:0]   sensitivity;
  logic [ENERGY_W-1:0] energy_floor;
  logic [GAP_W-1:0]    min_beat_gap_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity     <= SENS_RESET;
      energy_floor    <= FLOOR_RESET;
      min_beat_gap_us <= GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENSITIVITY:  sensitivity     <= cfg_data[SENS_W-1:0];
        CFG_ENERGY_FLOOR: energy_floor    <= cfg_data[ENERGY_W-1:0];
        CFG_MIN_GAP:      min_beat_gap_us <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // memories
  logic [ENERGY_W-1:0] e_mem [HISTORY_DEPTH];
  logic [GAP_W-1:0]    i_mem [INTERVAL_DEPTH];
  logic [ENERGY_W-1:0] e_rdata;
  logic [GAP_W-1:0]    i_rdata;

  // state
  state_t              state, state_next;
  logic [ENERGY_W-1:0] energy;
  logic [ESW-1:0]      energy_sum;
  logic [ECW-1:0]      energy_count;
  logic [HAW-1:0]      ring_head;
  logic [TIME_W-1:0]   now_us;
  logic [TIME_W-1:0]   last_beat_us;
  logic                beat_seen;
  logic [ISW-1:0]      interval_sum;
  logic [ICW-1:0]      interval_count;
  logic [IAW-1:0]      interval_head;
  logic [TEMPO_W-1:0]  tempo_reg;
  logic [TIME_W-1:0]   gap;
  logic [GAP_W-1:0]    iv;
  logic [PEW-1:0]      prod_e;
  logic [CMP_W-1:0]    prod_s;
  logic                beat;
  logic                rvalid;
  out_item_t           rdata;

  logic                accept;
  logic                e_rd;
  logic                i_rd;
  logic                div_start;
  logic                beat_now;
  logic [THR_W-1:0]    thr;
  logic [NUM_W-1:0]    div_num;
  logic                div_done;
  logic [NUM_W-1:0]    div_quot;
  logic                out_free;

  assign accept   = frames.valid & frames.ready;
  assign thr      = THR_W'(256) + THR_W'({sensitivity, 1'b0});
  assign beat_now = (CMP_W'({prod_e, 8'h00}) > prod_s) && (energy > energy_floor)
                    && (gap >= TIME_W'(min_beat_gap_us));
  assign div_num  = NUM_W'(TEMPO_NUM) * NUM_W'(interval_count);
  assign out_free = !rvalid || results.ready;

  assign results.valid = rvalid;
  assign results.data  = rdata;

  always_ff @(posedge clk) begin
    if (state == ST_ERD) begin
      e_mem[ring_head] <= energy;
    end
    if (e_rd) begin
      e_rdata <= e_mem[ring_head];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IRD) begin
      i_mem[interval_head] <= iv;
    end
    if (i_rd) begin
      i_rdata <= i_mem[interval_head];
    end
  end

  ebd_div #(
    .NUM_W (NUM_W),
    .DEN_W (ISW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (interval_sum),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    frames.ready = 1'b0;
    e_rd         = 1'b0;
    i_rd         = 1'b0;
    div_start    = 1'b0;
    case (state)
      ST_IDLE: begin
        frames.ready = 1'b1;
        e_rd         = frames.valid;
        if (frames.valid) begin
          state_next = ST_ERD;
        end
      end
      ST_ERD:   state_next = ST_MUL_E;
      ST_MUL_E: state_next = ST_MUL_S;
      ST_MUL_S: state_next = ST_CMP;
      ST_CMP: begin
        if (beat_now && beat_seen) begin
          i_rd       = 1'b1;
          state_next = ST_IRD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_IRD: state_next = ST_NUM;
      ST_NUM: begin
        if (interval_sum != '0) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum     <= '0;
      energy_count   <= '0;
      ring_head      <= '0;
      now_us         <= '0;
      last_beat_us   <= '0;
      beat_seen      <= 1'b0;
      interval_sum   <= '0;
      interval_count <= '0;
      interval_head  <= '0;
      tempo_reg      <= TEMPO_RESET;
      rvalid         <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        rvalid <= 1'b1;
      end else if (results.ready) begin
        rvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            now_us <= now_us + TIME_W'(frames.data.time_step_us);
          end
        end
        ST_ERD: begin
          if (energy_count == ECW'(HISTORY_DEPTH)) begin
            energy_sum <= energy_sum - ESW'(e_rdata) + ESW'(energy);
          end else begin
            energy_count <= energy_count + 1'b1;
            energy_sum   <= energy_sum + ESW'(energy);
          end
          ring_head <= (ring_head == HAW'(HISTORY_DEPTH - 1)) ? '0 : ring_head + 1'b1;
        end
        ST_CMP: begin
          if (beat_now) begin
            last_beat_us <= now_us;
            beat_seen    <= 1'b1;
          end
        end
        ST_IRD: begin
          if (interval_count == ICW'(INTERVAL_DEPTH)) begin
            interval_sum <= interval_sum - ISW'(i_rdata) + ISW'(iv);
          end else begin
            interval_count <= interval_count + 1'b1;
            interval_sum   <= interval_sum + ISW'(iv);
          end
          interval_head <= (interval_head == IAW'(INTERVAL_DEPTH - 1)) ? '0
                           : interval_head + 1'b1;
        end
        ST_DIV: begin
          if (div_done) begin
            if (div_quot < NUM_W'(TEMPO_MIN)) begin
              tempo_reg <= TEMPO_MIN;
            end else if (div_quot > NUM_W'(TEMPO_MAX)) begin
              tempo_reg <= TEMPO_MAX;
            end else begin
              tempo_reg <= div_quot[TEMPO_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          energy <= frames.data.frame_energy;
        end
      end
      ST_MUL_E: begin
        prod_e <= PEW'(energy) * PEW'(energy_count);
        gap    <= now_us - last_beat_us;
      end
      ST_MUL_S: prod_s <= CMP_W'(energy_sum) * CMP_W'(thr);
      ST_CMP: begin
        beat <= beat_now;
        iv   <= (gap > TIME_W'(GAP_MAX)) ? GAP_MAX : gap[GAP_W-1:0];
      end
      ST_DONE: begin
        if (out_free) begin
          rdata.beat      <= beat;
          rdata.tempo_x16 <= tempo_reg;
        end
      end
      default: ;
    endcase
  end

  `EBD_ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == ST_ERD, "accept did not start update")
  `EBD_ASSERT_IMPL(a_tempo_range, clk, rst, 1'b1, (tempo_reg >= TEMPO_MIN) && (tempo_reg <= TEMPO_MAX), "tempo out of range")
  `EBD_ASSERT_IMPL(a_icount_bound, clk, rst, 1'b1, interval_count <= ICW'(INTERVAL_DEPTH), "interval count overflow")
  `EBD_ASSERT_IMPL(a_result_has_history, clk, rst, rvalid, energy_count != '0, "result with empty history")
  `EBD_ASSERT_IMPL(a_div_done_state, clk, rst, div_done, state == ST_DIV, "divider done outside wait")

endmodule
